>>> src/sobb_pkg.sv
// Shared constants for the sphere versus oriented box collision block.
// Holds configuration register indexes, fixed-point formats and reset values.
// No dependencies.
`default_nettype none

package sobb_pkg;

    localparam int COORD_WIDTH_DEF = 20;
    localparam int FIELD_W         = 20;
    localparam int AXIS_W          = 16;
    localparam int AXIS_FRAC       = 14;
    localparam int CFG_DATA_W      = 60;
    localparam int CFG_ADDR_W      = 3;
    localparam int DELTA_W         = 17;
    localparam int DIST_W          = 17;
    localparam int D2_W            = 34;
    localparam int NUM_W           = 31;
    localparam int QUO_W           = 16;
    localparam int REM_W           = 18;
    localparam int NORM_W          = 17;
    localparam int SQRT_STEPS      = 17;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    localparam logic [47:0] AXIS_U_RST = 48'h0000_0000_4000;
    localparam logic [47:0] AXIS_V_RST = 48'h0000_4000_0000;
    localparam logic [47:0] AXIS_W_RST = 48'h4000_0000_0000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_BOX_CENTER  = 3'd0,
        CFG_HALF_EXTENT = 3'd1,
        CFG_AXIS_U      = 3'd2,
        CFG_AXIS_V      = 3'd3,
        CFG_AXIS_W      = 3'd4,
        CFG_BOX_VEL     = 3'd5,
        CFG_BOUNCE      = 3'd6,
        CFG_RADIUS      = 3'd7
    } cfg_idx_t;

endpackage

`default_nettype wire

>>> src/sphere_obb_collision_response.sv
// Sphere against oriented bounding box: collision test, push-out and bounce.
// Depends on sobb_pkg for formats, register indexes and reset values.
//
// Usage: each input beat on the s_axis group carries one sphere centre and
// velocity; each output beat on the m_axis group carries the corrected centre,
// the new velocity and, in tuser, the contact flag. Box geometry, box velocity,
// restitution and radius come from the write port (cfg_we, cfg_addr,
// cfg_wdata). Write them only while no beat is in flight; nothing checks it.
// The datapath is a 51-stage pipeline: projections, clamping, squared
// distance, a 17-step square root (one bit per stage), three 16-step
// restoring dividers for the normal (one quotient bit per stage) and the
// response arithmetic. One beat is accepted every cycle while no result
// waits on a deasserted m_axis_tready.
// Reset clears all stage valid bits and loads the register reset values (unit
// axes, everything else zero). When the receiver deasserts tready with a
// result waiting, the whole pipeline holds in place and s_axis_tready drops
// until the waiting beat is taken; nothing is lost or repeated.
`default_nettype none

module sphere_obb_collision_response
    import sobb_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z from the lowest bit up
    input  wire  [((6*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z
    output logic [((6*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // contact
    output logic                             m_axis_tuser,
    input  wire                              cfg_we,
    input  wire  [CFG_ADDR_W-1:0]            cfg_addr,
    input  wire  [CFG_DATA_W-1:0]            cfg_wdata
);

    localparam int CW   = COORD_WIDTH;
    localparam int TDW  = ((6*CW+7)/8)*8;
    localparam int DW   = ((CW > FIELD_W) ? CW : FIELD_W) + 1;
    localparam int PW   = DW + AXIS_W;
    localparam int AW   = PW + 2;
    localparam int LW   = AW - AXIS_FRAC;
    localparam int QW   = FIELD_W + 1;
    localparam int P2W  = QW + AXIS_W;
    localparam int A2W  = P2W + 2;
    localparam int TW   = A2W - AXIS_FRAC;
    localparam int EW   = ((DW > TW) ? DW : TW) + 1;
    localparam int VPW  = DW + NORM_W;
    localparam int VNW  = VPW + 2;
    localparam int PHW  = VNW - 24 + 19;
    localparam int PRW  = VNW + 19;
    localparam int SW   = PRW - 30;
    localparam int NSW  = NORM_W + SW;
    localparam int PPW  = NORM_W + 18;
    localparam int SBW  = NSW + 2;
    localparam int NS   = 51;
    localparam int ST_SQRT = 9;
    localparam int ST_DSET = ST_SQRT + SQRT_STEPS;
    localparam int ST_DIV  = ST_DSET + 1;
    localparam int ST_F1   = ST_DIV + QUO_W;

    typedef struct packed {
        logic [2:0][CW-1:0]      c;
        logic [2:0][CW-1:0]      v;
        logic [2:0][DW-1:0]      diff;
        logic [2:0][DELTA_W-1:0] delta;
        logic                    hit;
        logic [1:0]              sel;
        logic                    neg;
        logic [DIST_W-1:0]       distance;
        logic [2:0][NORM_W-1:0]  n;
        logic [2:0][CW-1:0]      newpos;
        logic                    vneg;
    } carry_t;

    function automatic logic [CW-1:0] sat_c(input logic signed [SBW-1:0] x);
        logic signed [SBW-1:0] hi;
        logic signed [SBW-1:0] lo;
        hi = (SBW'(1) <<< (CW-1)) - SBW'(1);
        lo = -hi - SBW'(1);
        if (x > hi)
            sat_c = hi[CW-1:0];
        else if (x < lo)
            sat_c = lo[CW-1:0];
        else
            sat_c = x[CW-1:0];
    endfunction

    logic [59:0] center_reg, half_reg, bvel_reg;
    logic [47:0] axu_reg, axv_reg, axw_reg;
    logic [16:0] bounce_reg;
    logic [15:0] radius_reg;
    logic [31:0] rr_reg;

    logic signed [FIELD_W-1:0] ctr [3];
    logic        [FIELD_W-1:0] half [3];
    logic signed [FIELD_W-1:0] bv [3];
    logic signed [AXIS_W-1:0]  ax [3][3];
    logic        [17:0]        kf;

    logic en;
    logic [NS-1:0] vld_reg;

    carry_t carry_reg  [NS-1];
    carry_t carry_next [NS-1];

    logic signed [PW-1:0]   p1_reg [3][3], p1_next [3][3];
    logic signed [LW-1:0]   l2_reg [3], l2_next [3];
    logic signed [QW-1:0]   q3_reg [3], q3_next [3];
    logic signed [LW:0]     pen3_reg [3], pen3_next [3];
    logic                   lneg3_reg [3], lneg3_next [3];
    logic signed [P2W-1:0]  p4_reg [3][3], p4_next [3][3];
    logic signed [TW-1:0]   t5_reg [3], t5_next [3];
    logic [31:0]            sq7_reg [3], sq7_next [3];
    logic [D2_W-1:0]        sqx_reg [SQRT_STEPS+1], sqx_next [SQRT_STEPS+1];
    logic [D2_W-1:0]        sqr_reg [SQRT_STEPS+1], sqr_next [SQRT_STEPS+1];
    logic [NUM_W-1:0]       num_reg [QUO_W+1][3], num_next [QUO_W+1][3];
    logic [DIST_W-1:0]      den_reg [QUO_W+1], den_next [QUO_W+1];
    logic [REM_W-1:0]       rem_reg [QUO_W+1][3], rem_next [QUO_W+1][3];
    logic [QUO_W-1:0]       quo_reg [QUO_W+1][3], quo_next [QUO_W+1][3];
    logic signed [DW-1:0]   vd1_reg [3], vd1_next [3];
    logic signed [17:0]     rd1_reg, rd1_next;
    logic signed [PPW-1:0]  pp2_reg [3], pp2_next [3];
    logic signed [VPW-1:0]  vp2_reg [3], vp2_next [3];
    logic signed [VNW-1:0]  vn3_reg, vn3_next;
    logic signed [PHW-1:0]  ph4_reg, ph4_next;
    logic [41:0]            pl4_reg, pl4_next;
    logic signed [PRW-1:0]  prod5_reg, prod5_next;
    logic signed [SW-1:0]   s6_reg, s6_next;
    logic signed [NSW-1:0]  ns7_reg [3], ns7_next [3];
    logic [CW-1:0]          opos_reg [3], opos_next [3];
    logic [CW-1:0]          ovel_reg [3], ovel_next [3];
    logic                   ocon_reg, ocon_next;

    assign en            = ~vld_reg[NS-1] | m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[NS-1];
    assign m_axis_tuser  = ocon_reg;
    assign m_axis_tdata  = TDW'({ovel_reg[2], ovel_reg[1], ovel_reg[0],
                                 opos_reg[2], opos_reg[1], opos_reg[0]});

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ctr[i]  = $signed(center_reg[FIELD_W*i +: FIELD_W]);
            half[i] = half_reg[FIELD_W*i +: FIELD_W];
            bv[i]   = $signed(bvel_reg[FIELD_W*i +: FIELD_W]);
            ax[0][i] = $signed(axu_reg[AXIS_W*i +: AXIS_W]);
            ax[1][i] = $signed(axv_reg[AXIS_W*i +: AXIS_W]);
            ax[2][i] = $signed(axw_reg[AXIS_W*i +: AXIS_W]);
        end
        kf = 18'(ONE_Q16) + 18'((bounce_reg > ONE_Q16) ? ONE_Q16 : bounce_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= '0;
            half_reg   <= '0;
            axu_reg    <= AXIS_U_RST;
            axv_reg    <= AXIS_V_RST;
            axw_reg    <= AXIS_W_RST;
            bvel_reg   <= '0;
            bounce_reg <= '0;
            radius_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_BOX_CENTER:  center_reg <= cfg_wdata[59:0];
                CFG_HALF_EXTENT: half_reg   <= cfg_wdata[59:0];
                CFG_AXIS_U:      axu_reg    <= cfg_wdata[47:0];
                CFG_AXIS_V:      axv_reg    <= cfg_wdata[47:0];
                CFG_AXIS_W:      axw_reg    <= cfg_wdata[47:0];
                CFG_BOX_VEL:     bvel_reg   <= cfg_wdata[59:0];
                CFG_BOUNCE:      bounce_reg <= cfg_wdata[16:0];
                CFG_RADIUS:      radius_reg <= cfg_wdata[15:0];
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rr_reg <= 32'(radius_reg) * 32'(radius_reg);
    end

    always_comb
    begin
        logic signed [CW-1:0]   ci;
        logic signed [AW-1:0]   acc;
        logic signed [A2W-1:0]  acc2;
        logic signed [LW-1:0]   hl;
        logic signed [LW:0]     la;
        logic signed [EW-1:0]   de;
        logic signed [2*DELTA_W-1:0] sq;
        logic [D2_W-1:0]        d2;
        logic [D2_W:0]          trial;
        logic [D2_W-1:0]        bitv;
        logic [DELTA_W-1:0]     dabs;
        logic [DIST_W-1:0]      distance;
        logic [REM_W-1:0]       sh;
        logic signed [NORM_W-1:0] nn;
        logic signed [NORM_W-1:0] axs;
        logic signed [DELTA_W-1:0] dl;
        logic signed [SBW-1:0]  sv;
        logic signed [VNW-1:0]  vsum;

        for (int s = 1; s < NS-1; s++)
            carry_next[s] = carry_reg[s-1];

        // stage 0: capture and offset from the box centre
        carry_next[0] = carry_reg[0];
        for (int k = 0; k < 3; k++)
        begin
            carry_next[0].c[k]    = s_axis_tdata[CW*k +: CW];
            carry_next[0].v[k]    = s_axis_tdata[CW*(3+k) +: CW];
            ci                    = $signed(s_axis_tdata[CW*k +: CW]);
            carry_next[0].diff[k] = DW'(ci) - DW'(ctr[k]);
        end

        // stage 1: projection products
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                p1_next[i][k] = PW'(ax[i][k]) * PW'($signed(carry_reg[0].diff[k]));

        // stage 2: projections, rounded
        for (int i = 0; i < 3; i++)
        begin
            acc = AW'(p1_reg[i][0]) + AW'(p1_reg[i][1]) + AW'(p1_reg[i][2])
                + AW'(2**(AXIS_FRAC-1));
            l2_next[i] = LW'(acc >>> AXIS_FRAC);
        end

        // stage 3: clamp and penetration depth per axis
        for (int i = 0; i < 3; i++)
        begin
            hl = LW'($signed({1'b0, half[i]}));
            if (l2_reg[i] > hl)
                q3_next[i] = QW'(hl);
            else if (l2_reg[i] < -hl)
                q3_next[i] = QW'(-hl);
            else
                q3_next[i] = QW'(l2_reg[i]);
            la = (l2_reg[i] < 0) ? -(LW+1)'(l2_reg[i]) : (LW+1)'(l2_reg[i]);
            pen3_next[i]  = (LW+1)'(hl) - la;
            lneg3_next[i] = l2_reg[i][LW-1];
        end

        // stage 4: closest point products and least penetration axis
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                p4_next[i][k] = P2W'(ax[i][k]) * P2W'(q3_reg[i]);
        if (pen3_reg[0] <= pen3_reg[1] && pen3_reg[0] <= pen3_reg[2])
        begin
            carry_next[4].sel = 2'd0;
            carry_next[4].neg = lneg3_reg[0];
        end
        else if (pen3_reg[1] <= pen3_reg[2])
        begin
            carry_next[4].sel = 2'd1;
            carry_next[4].neg = lneg3_reg[1];
        end
        else
        begin
            carry_next[4].sel = 2'd2;
            carry_next[4].neg = lneg3_reg[2];
        end

        // stage 5: closest point in world axes, relative to the centre
        for (int k = 0; k < 3; k++)
        begin
            acc2 = A2W'(p4_reg[0][k]) + A2W'(p4_reg[1][k]) + A2W'(p4_reg[2][k])
                 + A2W'(2**(AXIS_FRAC-1));
            t5_next[k] = TW'(acc2 >>> AXIS_FRAC);
        end

        // stage 6: offset from closest point and range check
        carry_next[6].hit = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            de = EW'($signed(carry_reg[5].diff[k])) - EW'(t5_reg[k]);
            carry_next[6].delta[k] = de[DELTA_W-1:0];
            if (de > EW'(65535) || de < -EW'(65535))
                carry_next[6].hit = 1'b0;
        end

        // stage 7: squares
        for (int k = 0; k < 3; k++)
        begin
            dl = $signed(carry_reg[6].delta[k]);
            sq = (2*DELTA_W)'(dl) * (2*DELTA_W)'(dl);
            sq7_next[k] = sq[31:0];
        end

        // stage 8: squared distance against squared radius
        d2 = D2_W'(sq7_reg[0]) + D2_W'(sq7_reg[1]) + D2_W'(sq7_reg[2]);
        sqx_next[0] = d2;
        sqr_next[0] = '0;
        carry_next[8].hit = carry_reg[7].hit && (d2 < D2_W'(rr_reg));

        // square root, one result bit per stage
        for (int j = 0; j < SQRT_STEPS; j++)
        begin
            bitv  = D2_W'(1) << (2*(SQRT_STEPS-1-j));
            trial = (D2_W+1)'(sqr_reg[j]) + (D2_W+1)'(bitv);
            if ((D2_W+1)'(sqx_reg[j]) >= trial)
            begin
                sqx_next[j+1] = sqx_reg[j] - trial[D2_W-1:0];
                sqr_next[j+1] = (sqr_reg[j] >> 1) + bitv;
            end
            else
            begin
                sqx_next[j+1] = sqx_reg[j];
                sqr_next[j+1] = sqr_reg[j] >> 1;
            end
        end

        // divider setup
        distance = sqr_reg[SQRT_STEPS][DIST_W-1:0];
        carry_next[ST_DSET].distance = distance;
        den_next[0] = (distance == '0) ? DIST_W'(1) : distance;
        for (int k = 0; k < 3; k++)
        begin
            dl   = $signed(carry_reg[ST_DSET-1].delta[k]);
            dabs = (dl < 0) ? DELTA_W'(-dl) : DELTA_W'(dl);
            num_next[0][k] = NUM_W'({dabs[15:0], {AXIS_FRAC{1'b0}}})
                           + NUM_W'(distance >> 1);
            rem_next[0][k] = REM_W'(num_next[0][k][NUM_W-1:QUO_W]);
            quo_next[0][k] = '0;
        end

        // restoring dividers, one quotient bit per stage
        for (int i = 0; i < QUO_W; i++)
        begin
            den_next[i+1] = den_reg[i];
            for (int k = 0; k < 3; k++)
            begin
                num_next[i+1][k] = num_reg[i][k];
                sh = {rem_reg[i][k][REM_W-2:0], num_reg[i][k][QUO_W-1-i]};
                if (sh >= REM_W'(den_reg[i]))
                begin
                    rem_next[i+1][k] = sh - REM_W'(den_reg[i]);
                    quo_next[i+1][k] = {quo_reg[i][k][QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[i+1][k] = sh;
                    quo_next[i+1][k] = {quo_reg[i][k][QUO_W-2:0], 1'b0};
                end
            end
        end

        // F1: contact normal and response operands
        for (int k = 0; k < 3; k++)
        begin
            case (carry_reg[ST_F1-1].sel)
                2'd0:    axs = NORM_W'(ax[0][k]);
                2'd1:    axs = NORM_W'(ax[1][k]);
                default: axs = NORM_W'(ax[2][k]);
            endcase
            dl = $signed(carry_reg[ST_F1-1].delta[k]);
            if (carry_reg[ST_F1-1].distance == '0)
                nn = carry_reg[ST_F1-1].neg ? -axs : axs;
            else
                nn = (dl < 0) ? -$signed(NORM_W'(quo_reg[QUO_W][k]))
                              : $signed(NORM_W'(quo_reg[QUO_W][k]));
            carry_next[ST_F1].n[k] = nn;
            vd1_next[k] = DW'($signed(carry_reg[ST_F1-1].v[k])) - DW'(bv[k]);
        end
        rd1_next = $signed({2'b00, radius_reg})
                 - $signed({1'b0, carry_reg[ST_F1-1].distance});

        // F2: push-out and normal velocity products
        for (int k = 0; k < 3; k++)
        begin
            pp2_next[k] = PPW'($signed(carry_reg[ST_F1].n[k])) * PPW'(rd1_reg);
            vp2_next[k] = VPW'(vd1_reg[k]) * VPW'($signed(carry_reg[ST_F1].n[k]));
        end

        // F3: corrected centre and normal velocity
        for (int k = 0; k < 3; k++)
        begin
            sv = SBW'($signed(carry_reg[ST_F1+1].c[k]))
               + SBW'((pp2_reg[k] + PPW'(2**(AXIS_FRAC-1))) >>> AXIS_FRAC);
            carry_next[ST_F1+2].newpos[k] = sat_c(sv);
        end
        vsum = VNW'(vp2_reg[0]) + VNW'(vp2_reg[1]) + VNW'(vp2_reg[2]);
        vn3_next = vsum;
        carry_next[ST_F1+2].vneg = vsum[VNW-1];

        // F4: restitution product, split in two halves
        ph4_next = PHW'(vn3_reg >>> 24) * PHW'($signed({1'b0, kf}));
        pl4_next = 42'(vn3_reg[23:0]) * 42'(kf);

        // F5: recombine
        prod5_next = (PRW'(ph4_reg) <<< 24) + PRW'($signed({1'b0, pl4_reg}));

        // F6: impulse scale
        s6_next = SW'((prod5_reg + PRW'(2**29)) >>> 30);

        // F7: impulse along the normal
        for (int k = 0; k < 3; k++)
            ns7_next[k] = NSW'($signed(carry_reg[ST_F1+5].n[k])) * NSW'(s6_reg);

        // F8: result selection
        for (int k = 0; k < 3; k++)
        begin
            sv = SBW'($signed(carry_reg[ST_F1+6].v[k]))
               - SBW'((ns7_reg[k] + NSW'(2**(AXIS_FRAC-1))) >>> AXIS_FRAC);
            if (carry_reg[ST_F1+6].hit)
            begin
                opos_next[k] = carry_reg[ST_F1+6].newpos[k];
                ovel_next[k] = carry_reg[ST_F1+6].vneg ? sat_c(sv)
                                                       : carry_reg[ST_F1+6].v[k];
            end
            else
            begin
                opos_next[k] = carry_reg[ST_F1+6].c[k];
                ovel_next[k] = carry_reg[ST_F1+6].v[k];
            end
        end
        ocon_next = carry_reg[ST_F1+6].hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NS-2:0], s_axis_tvalid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            carry_reg <= carry_next;
            p1_reg    <= p1_next;
            l2_reg    <= l2_next;
            q3_reg    <= q3_next;
            pen3_reg  <= pen3_next;
            lneg3_reg <= lneg3_next;
            p4_reg    <= p4_next;
            t5_reg    <= t5_next;
            sq7_reg   <= sq7_next;
            sqx_reg   <= sqx_next;
            sqr_reg   <= sqr_next;
            num_reg   <= num_next;
            den_reg   <= den_next;
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
            vd1_reg   <= vd1_next;
            rd1_reg   <= rd1_next;
            pp2_reg   <= pp2_next;
            vp2_reg   <= vp2_next;
            vn3_reg   <= vn3_next;
            ph4_reg   <= ph4_next;
            pl4_reg   <= pl4_next;
            prod5_reg <= prod5_next;
            s6_reg    <= s6_next;
            ns7_reg   <= ns7_next;
            opos_reg  <= opos_next;
            ovel_reg  <= ovel_next;
            ocon_reg  <= ocon_next;
        end
    end

endmodule

`default_nettype wire

>>> sim/tb_sphere_obb_collision_response.sv
// Testbench for the sphere versus oriented box collision block.
// Drives sphere beats and box settings, predicts each response and checks it.
// Depends on sobb_pkg and sphere_obb_collision_response.
`timescale 1ns / 100ps

module tb_sphere_obb_collision_response;
    import sobb_pkg::*;

    localparam int CW = 20;
    localparam int DW = ((6*CW+7)/8)*8;
    localparam int LATENCY = 51;
    localparam int WATCHDOG = 20000;

    typedef struct {
        logic [DW-1:0] data;
        logic          hit;
    } response_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [DW-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [DW-1:0] m_axis_tdata;
    logic m_axis_tuser;
    logic cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic [59:0] center_r, half_r, bvel_r;
    logic [47:0] axis_r [3];
    logic [16:0] bounce_r;
    logic [15:0] radius_r;

    response_t pending_responses[$];
    int errors = 0;
    int beats_sent = 0;
    int beats_checked = 0;
    int contacts_seen = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off = 0;

    sphere_obb_collision_response dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic longint round_shift(longint x, int s);
        longint y;
        y = x + (longint'(1) << (s - 1));
        return y >>> s;
    endfunction

    function automatic longint clip(longint x);
        if (x > 524287) return 524287;
        if (x < -524288) return -524288;
        return x;
    endfunction

    function automatic longint int_sqrt(longint x);
        longint r;
        r = 0;
        for (int b = 31; b >= 0; b--)
            if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= x)
                r = r + (longint'(1) << b);
        return r;
    endfunction

    function automatic longint mag(longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic response_t collide(logic [DW-1:0] din);
        response_t res;
        longint c[3], v[3], ctr[3], half[3], bv[3], ax[3][3], l[3], q[3];
        longint delta[3], n[3], res_pos[3], res_vel[3];
        longint r, e, d2, distance, vn, acc, s, p0, p1, p2, m;
        bit hit;
        int sel;
        hit = 1;
        d2 = 0;
        vn = 0;
        for (int i = 0; i < 3; i++)
        begin
            c[i] = longint'($signed(din[i*CW +: CW]));
            v[i] = longint'($signed(din[(3+i)*CW +: CW]));
            ctr[i] = longint'($signed(center_r[i*20 +: 20]));
            half[i] = longint'(half_r[i*20 +: 20]);
            bv[i] = longint'($signed(bvel_r[i*20 +: 20]));
            for (int k = 0; k < 3; k++)
                ax[i][k] = longint'($signed(axis_r[i][k*16 +: 16]));
        end
        r = longint'(radius_r);
        e = bounce_r > ONE_Q16 ? 65536 : longint'(bounce_r);
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += (c[k] - ctr[k]) * ax[i][k];
            l[i] = round_shift(acc, AXIS_FRAC);
            q[i] = l[i] > half[i] ? half[i] : (l[i] < -half[i] ? -half[i] : l[i]);
        end
        for (int k = 0; k < 3; k++)
        begin
            acc = 0;
            for (int i = 0; i < 3; i++) acc += ax[i][k] * q[i];
            delta[k] = c[k] - (ctr[k] + round_shift(acc, AXIS_FRAC));
            if (mag(delta[k]) > 65535) hit = 0;
        end
        if (hit)
        begin
            for (int k = 0; k < 3; k++) d2 += delta[k] * delta[k];
            if (d2 >= r * r) hit = 0;
        end
        for (int k = 0; k < 3; k++)
        begin
            res_pos[k] = clip(c[k]);
            res_vel[k] = clip(v[k]);
        end
        if (hit)
        begin
            distance = int_sqrt(d2);
            if (distance > 0)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    m = (mag(delta[k]) * 16384 + distance / 2) / distance;
                    n[k] = delta[k] < 0 ? -m : m;
                end
            end
            else
            begin
                p0 = half[0] - mag(l[0]);
                p1 = half[1] - mag(l[1]);
                p2 = half[2] - mag(l[2]);
                sel = (p0 <= p1 && p0 <= p2) ? 0 : (p1 <= p2 ? 1 : 2);
                for (int k = 0; k < 3; k++)
                    n[k] = l[sel] < 0 ? -ax[sel][k] : ax[sel][k];
            end
            for (int k = 0; k < 3; k++)
            begin
                res_pos[k] = clip(c[k] + round_shift(n[k] * (r - distance), AXIS_FRAC));
                vn += (v[k] - bv[k]) * n[k];
            end
            if (vn < 0)
            begin
                s = round_shift((65536 + e) * vn, 30);
                for (int k = 0; k < 3; k++)
                    res_vel[k] = clip(v[k] - round_shift(n[k] * s, AXIS_FRAC));
            end
        end
        res.data = '0;
        for (int k = 0; k < 3; k++)
        begin
            res.data[k*CW +: CW] = res_pos[k][CW-1:0];
            res.data[(3+k)*CW +: CW] = res_vel[k][CW-1:0];
        end
        res.hit = hit;
        return res;
    endfunction

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 20'h7FFFF;
            1: return 20'h80000;
            2: return CW'($urandom_range(0, 8191) - 4096);
            default: return CW'($urandom);
        endcase
    endfunction

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_BOX_CENTER:  center_r = value[59:0];
            CFG_HALF_EXTENT: half_r = value[59:0];
            CFG_AXIS_U:      axis_r[0] = value[47:0];
            CFG_AXIS_V:      axis_r[1] = value[47:0];
            CFG_AXIS_W:      axis_r[2] = value[47:0];
            CFG_BOX_VEL:     bvel_r = value[59:0];
            CFG_BOUNCE:      bounce_r = value[16:0];
            CFG_RADIUS:      radius_r = value[15:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_sphere(logic [DW-1:0] beat);
        while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= beat;
        pending_responses.push_back(collide(beat));
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        beats_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_responses.size() > 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [DW-1:0] sphere_beat(longint p[3], longint w[3]);
        logic [DW-1:0] b;
        b = '0;
        for (int k = 0; k < 3; k++)
        begin
            b[k*CW +: CW] = p[k][CW-1:0];
            b[(3+k)*CW +: CW] = w[k][CW-1:0];
        end
        return b;
    endfunction

    function automatic logic [DW-1:0] near_box_beat();
        longint p[3], w[3];
        for (int k = 0; k < 3; k++)
        begin
            p[k] = longint'($signed(center_r[k*20 +: 20]))
                 + longint'($urandom_range(0, 40000)) - 20000;
            w[k] = longint'($urandom_range(0, 40000)) - 20000;
        end
        return sphere_beat(p, w);
    endfunction

    task automatic setup_unit_box(logic [16:0] bounce);
        write_reg(CFG_BOX_CENTER, {20'd0, 20'd0, 20'd0});
        write_reg(CFG_HALF_EXTENT, {20'd4096, 20'd4096, 20'd4096});
        write_reg(CFG_AXIS_U, AXIS_U_RST);
        write_reg(CFG_AXIS_V, AXIS_V_RST);
        write_reg(CFG_AXIS_W, AXIS_W_RST);
        write_reg(CFG_BOX_VEL, '0);
        write_reg(CFG_BOUNCE, bounce);
        write_reg(CFG_RADIUS, 16'd8192);
    endtask

    task automatic test_directed();
        longint p[3], w[3];
        setup_unit_box(17'd32768);
        p = '{0, 0, 0}; w = '{0, 0, 0};
        send_sphere(sphere_beat(p, w));
        p = '{100, 50, 10}; w = '{-4096, 0, 0};
        send_sphere(sphere_beat(p, w));
        p = '{-100, 50, 10}; w = '{100, 0, 0};
        send_sphere(sphere_beat(p, w));
        p = '{5000, 0, 0}; w = '{-4096, 100, 0};
        send_sphere(sphere_beat(p, w));
        p = '{5000, 0, 0}; w = '{4096, 0, 0};
        send_sphere(sphere_beat(p, w));
        p = '{5000, 5000, 5000}; w = '{-4096, -4096, -4096};
        send_sphere(sphere_beat(p, w));
        p = '{20000, 0, 0}; w = '{1, 2, 3};
        send_sphere(sphere_beat(p, w));
        p = '{524287, 524287, 524287}; w = '{524287, 524287, 524287};
        send_sphere(sphere_beat(p, w));
        p = '{-524288, -524288, -524288}; w = '{-524288, -524288, -524288};
        send_sphere(sphere_beat(p, w));
        p = '{0, 0, 4096}; w = '{0, 0, -524288};
        send_sphere(sphere_beat(p, w));
        drain();
        write_reg(CFG_BOUNCE, 17'h1FFFF);
        write_reg(CFG_RADIUS, 16'hFFFF);
        write_reg(CFG_HALF_EXTENT, {20'hFFFFF, 20'hFFFFF, 20'hFFFFF});
        p = '{1000, -2000, 3000}; w = '{524287, -524288, 100};
        send_sphere(sphere_beat(p, w));
        p = '{-524288, 524287, 0}; w = '{0, 0, 0};
        send_sphere(sphere_beat(p, w));
        drain();
        write_reg(CFG_HALF_EXTENT, {20'd1000, 20'd3000, 20'd3000});
        write_reg(CFG_AXIS_U, {16'h8000, 16'h7FFF, 16'h4000});
        write_reg(CFG_BOX_VEL, {20'h80000, 20'h7FFFF, 20'h00100});
        write_reg(CFG_BOX_CENTER, {20'hFF000, 20'h01000, 20'h80000});
        p = '{-524288, 4096, -4096}; w = '{-300, 400, 500};
        send_sphere(sphere_beat(p, w));
        p = '{-520000, 4000, -4000}; w = '{300, -400, -500};
        send_sphere(sphere_beat(p, w));
        drain();
    endtask

    task automatic random_phase(int count, int sidle, int rstall, bit rotate_box);
        drain();
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        write_reg(CFG_BOX_CENTER, {20'($urandom_range(0, 32767) - 16384),
                                   20'($urandom_range(0, 32767) - 16384),
                                   20'($urandom_range(0, 32767) - 16384)});
        write_reg(CFG_HALF_EXTENT, {20'($urandom_range(0, 12000)),
                                    20'($urandom_range(0, 12000)),
                                    20'($urandom_range(0, 12000))});
        if (rotate_box)
        begin
            write_reg(CFG_AXIS_U, {16'($urandom), 16'($urandom), 16'($urandom)});
            write_reg(CFG_AXIS_V, {16'($urandom_range(0, 32767) - 16384), 16'd11585, 16'd0});
            write_reg(CFG_AXIS_W, {16'd11585, 16'($urandom), 16'h8000});
        end
        else
        begin
            write_reg(CFG_AXIS_U, {16'd0, 16'd11585, 16'd11585});
            write_reg(CFG_AXIS_V, {16'd0, 16'd11585, 16'hD2BF});
            write_reg(CFG_AXIS_W, AXIS_W_RST);
        end
        write_reg(CFG_BOX_VEL, {20'($urandom), 20'($urandom_range(0, 8191) - 4096),
                                20'($urandom_range(0, 8191) - 4096)});
        write_reg(CFG_BOUNCE, 17'($urandom_range(0, 70000)));
        write_reg(CFG_RADIUS, 16'($urandom_range(2000, 65535)));
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                send_sphere({rand_coord(), rand_coord(), rand_coord(),
                             rand_coord(), rand_coord(), rand_coord()});
            else
                send_sphere(near_box_beat());
        end
    endtask

    task automatic test_backpressure();
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 300;
        for (int i = 0; i < 80; i++) send_sphere(near_box_beat());
    endtask

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (pending_responses.size() == 0)
            begin
                $error("unexpected result beat");
                errors++;
            end
            else
            begin
                response_t want;
                want = pending_responses.pop_front();
                for (int k = 0; k < 6; k++)
                    if (m_axis_tdata[k*CW +: CW] !== want.data[k*CW +: CW])
                    begin
                        $error("field %s: expected %h, got %h",
                               k < 3 ? "new_pos" : "new_vel",
                               want.data[k*CW +: CW], m_axis_tdata[k*CW +: CW]);
                        errors++;
                    end
                if (m_axis_tuser !== want.hit)
                begin
                    $error("field contact: expected %b, got %b", want.hit, m_axis_tuser);
                    errors++;
                end
                if (want.hit) contacts_seen++;
                beats_checked++;
            end
        end
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(1, 100) > recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("tb_sphere_obb_collision_response: FAIL");
            $finish;
        end
    end

    initial
    begin
        center_r = '0; half_r = '0; bvel_r = '0; bounce_r = '0; radius_r = '0;
        axis_r[0] = AXIS_U_RST; axis_r[1] = AXIS_V_RST; axis_r[2] = AXIS_W_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        random_phase(120, 0, 0, 0);
        random_phase(120, 49, 0, 1);
        random_phase(120, 0, 49, 0);
        random_phase(120, 6, 6, 1);
        test_backpressure();
        drain();
        $display("Checked %0d of %0d sphere beats, %0d with contact, across box setups",
                 beats_checked, beats_sent, contacts_seen);
        if (errors == 0 && pending_responses.size() == 0)
            $display("tb_sphere_obb_collision_response: PASS");
        else
            $display("tb_sphere_obb_collision_response: FAIL");
        $finish;
    end

endmodule

>>> sphere_obb_collision_response.f
src/sobb_pkg.sv
src/sphere_obb_collision_response.sv
sim/tb_sphere_obb_collision_response.sv
